/* hdl/csb_pkg.sv */
package csb_pkg;

   localparam int KindW      = 4;
   localparam int ValueW     = 32;
   localparam int ItemCountW = 6;

   typedef enum logic [3:0] {
      KIND_START,
      KIND_END,
      KIND_ADVANCE,
      KIND_INSERT,
      KIND_INSERT_FRONT,
      KIND_ATTACH,
      KIND_ATTACH_BACK,
      KIND_REMOVE,
      KIND_REMOVE_FRONT,
      KIND_READ
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_NO_ITEM,
      STATUS_EMPTY
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_UP,
      SHIFT_DOWN
   } shift_type;

   typedef struct packed {
      shift_type  shift;
      status_type status;
   } plan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_LOOKUP,
      ST_RESPOND
   } state_type;

endpackage

/* hdl/cursor_sequence_buffer.sv */
// Sequence: a request that moves no entries passes through LOOKUP and RESPOND before rsp_valid
// rises; a removal first passes through SHIFT, and an insert or attach through SHIFT and PLACE,
// where SHIFT moves the entries one entry per cycle through the RAM port.
// Throughput: one request at a time; the next is taken once the response is registered.
// Reset clears count, cursor and handshake state; the entry RAM is not cleared.
module cursor_sequence_buffer #(
   parameter int DEPTH       = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [csb_pkg::KindW-1:0]       req_kind,
   input  logic [csb_pkg::ValueW-1:0]      req_entry,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [csb_pkg::ValueW-1:0]      rsp_current_value,
   output logic                            rsp_has_item,
   output logic [csb_pkg::ItemCountW-1:0]  rsp_item_count,
   output logic [1:0]                      rsp_status
);

   localparam int StoreW = (VALUE_WIDTH < csb_pkg::ValueW) ? VALUE_WIDTH : csb_pkg::ValueW;
   localparam int CountW = $clog2(DEPTH + 1);
   localparam int IdxW   = $clog2(DEPTH);

   csb_pkg::state_type  state_ff, state_in;
   logic [CountW-1:0]   count_ff;
   logic [CountW-1:0]   cursor_ff;
   logic [CountW-1:0]   moves_ff;
   logic [IdxW-1:0]     pos_ff;
   logic [IdxW-1:0]     rd_addr_ff;
   logic [IdxW-1:0]     wr_addr_ff;
   logic                pend_ff;
   csb_pkg::shift_type  shift_ff;
   csb_pkg::status_type status_ff;
   logic [StoreW-1:0]   value_ff;

   logic                rsp_valid_ff;
   logic [csb_pkg::ValueW-1:0]     rsp_value_ff;
   logic                rsp_has_ff;
   logic [csb_pkg::ItemCountW-1:0] rsp_count_ff;
   csb_pkg::status_type rsp_status_ff;

   csb_pkg::plan_type   plan;
   logic [IdxW-1:0]     dec_pos;
   logic [IdxW-1:0]     dec_first;
   logic [CountW-1:0]   dec_moves;
   logic [CountW-1:0]   dec_cursor;
   logic [CountW-1:0]   dec_count;

   logic                ram_wr_en;
   logic [IdxW-1:0]     ram_wr_addr;
   logic [StoreW-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [IdxW-1:0]     ram_rd_addr;
   logic [StoreW-1:0]   ram_rd_data;

   logic                accept;
   logic                has_item;
   logic                rsp_free;
   logic                rsp_load;
   logic                shift_step;
   logic [csb_pkg::ValueW-1:0]     rd_wide;
   logic [csb_pkg::ItemCountW-1:0] count_narrow;

   csb_decode #(.DEPTH(DEPTH)) u_decode (
      .kind        (req_kind),
      .count       (count_ff),
      .cursor      (cursor_ff),
      .plan        (plan),
      .pos         (dec_pos),
      .first_rd    (dec_first),
      .moves       (dec_moves),
      .next_cursor (dec_cursor),
      .next_count  (dec_count)
   );

   csb_ram #(.WIDTH(StoreW), .DEPTH(DEPTH)) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   if (StoreW < csb_pkg::ValueW) begin : g_value_pad
      assign rd_wide = {{(csb_pkg::ValueW - StoreW){1'b0}}, ram_rd_data};
   end else begin : g_value_full
      assign rd_wide = ram_rd_data;
   end

   if (CountW < csb_pkg::ItemCountW) begin : g_count_pad
      assign count_narrow = {{(csb_pkg::ItemCountW - CountW){1'b0}}, count_ff};
   end else begin : g_count_cut
      assign count_narrow = count_ff[csb_pkg::ItemCountW-1:0];
   end

   assign accept   = req_valid && !req_stall;
   assign has_item = cursor_ff < count_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (plan.shift == csb_pkg::SHIFT_NONE) ? csb_pkg::ST_LOOKUP
                                                              : csb_pkg::ST_SHIFT;
            end
         end
         csb_pkg::ST_SHIFT: begin
            if (moves_ff == '0) begin
               state_in = (shift_ff == csb_pkg::SHIFT_UP) ? csb_pkg::ST_PLACE
                                                          : csb_pkg::ST_LOOKUP;
            end
         end
         csb_pkg::ST_PLACE:   state_in = csb_pkg::ST_LOOKUP;
         csb_pkg::ST_LOOKUP:  state_in = csb_pkg::ST_RESPOND;
         csb_pkg::ST_RESPOND: begin
            if (rsp_free) state_in = csb_pkg::ST_IDLE;
         end
         default: state_in = csb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_addr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_addr_ff;
      shift_step  = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         csb_pkg::ST_IDLE: req_stall = 1'b0;
         csb_pkg::ST_SHIFT: begin
            // write back the entry read last cycle while fetching the next one
            ram_wr_en = pend_ff;
            if (moves_ff != '0) begin
               ram_rd_en  = 1'b1;
               shift_step = 1'b1;
            end
         end
         csb_pkg::ST_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = value_ff;
         end
         csb_pkg::ST_LOOKUP: begin
            ram_rd_en   = has_item;
            ram_rd_addr = cursor_ff[IdxW-1:0];
         end
         csb_pkg::ST_RESPOND: rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csb_pkg::ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= shift_step;
         if (accept) begin
            count_ff  <= dec_count;
            cursor_ff <= dec_cursor;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff     <= dec_pos;
         rd_addr_ff <= dec_first;
         moves_ff   <= dec_moves;
         shift_ff   <= plan.shift;
         status_ff  <= plan.status;
         value_ff   <= req_entry[StoreW-1:0];
      end else if (shift_step) begin
         moves_ff <= moves_ff - CountW'(1);
         if (shift_ff == csb_pkg::SHIFT_UP) begin
            rd_addr_ff <= rd_addr_ff - IdxW'(1);
            wr_addr_ff <= rd_addr_ff + IdxW'(1);
         end else begin
            rd_addr_ff <= rd_addr_ff + IdxW'(1);
            wr_addr_ff <= rd_addr_ff - IdxW'(1);
         end
      end
      if (rsp_load) begin
         rsp_value_ff  <= has_item ? rd_wide : '0;
         rsp_has_ff    <= has_item;
         rsp_count_ff  <= count_narrow;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_value = rsp_value_ff;
   assign rsp_has_item      = rsp_has_ff;
   assign rsp_item_count    = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

/* hdl/csb_ram.sv */
module csb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/csb_decode.sv */
module csb_decode #(
   parameter int DEPTH = 32
) (
   input  logic [csb_pkg::KindW-1:0]   kind,
   input  logic [$clog2(DEPTH+1)-1:0]  count,
   input  logic [$clog2(DEPTH+1)-1:0]  cursor,
   output csb_pkg::plan_type           plan,
   output logic [$clog2(DEPTH)-1:0]    pos,
   output logic [$clog2(DEPTH)-1:0]    first_rd,
   output logic [$clog2(DEPTH+1)-1:0]  moves,
   output logic [$clog2(DEPTH+1)-1:0]  next_cursor,
   output logic [$clog2(DEPTH+1)-1:0]  next_count
);

   localparam int CountW = $clog2(DEPTH + 1);
   localparam int IdxW   = $clog2(DEPTH);
   localparam logic [CountW-1:0] One  = CountW'(1);
   localparam logic [CountW-1:0] Full = CountW'(DEPTH);

   logic              item;
   logic              full;
   logic              empty;
   logic [CountW-1:0] cursor_inc;
   logic [CountW-1:0] pos_c;
   logic [CountW-1:0] last_rd;

   assign item       = cursor < count;
   assign full       = count == Full;
   assign empty      = count == '0;
   assign cursor_inc = cursor + One;

   always_comb begin
      plan.shift  = csb_pkg::SHIFT_NONE;
      plan.status = csb_pkg::STATUS_OK;
      pos_c       = cursor;
      next_cursor = cursor;
      next_count  = count;
      unique case (csb_pkg::kind_type'(kind))
         csb_pkg::KIND_START: begin
            if (empty) plan.status = csb_pkg::STATUS_EMPTY;
            else next_cursor = '0;
         end
         csb_pkg::KIND_END: begin
            if (empty) plan.status = csb_pkg::STATUS_EMPTY;
            else next_cursor = count - One;
         end
         csb_pkg::KIND_ADVANCE: begin
            if (item) next_cursor = cursor_inc;
            else plan.status = csb_pkg::STATUS_NO_ITEM;
         end
         csb_pkg::KIND_INSERT: begin
            if (full) plan.status = csb_pkg::STATUS_FULL;
            else begin
               plan.shift = csb_pkg::SHIFT_UP;
               pos_c      = item ? cursor : '0;
            end
         end
         csb_pkg::KIND_INSERT_FRONT: begin
            if (full) plan.status = csb_pkg::STATUS_FULL;
            else begin
               plan.shift = csb_pkg::SHIFT_UP;
               pos_c      = '0;
            end
         end
         csb_pkg::KIND_ATTACH: begin
            if (full) plan.status = csb_pkg::STATUS_FULL;
            else begin
               plan.shift = csb_pkg::SHIFT_UP;
               pos_c      = (item && (cursor_inc < count)) ? cursor_inc : count;
            end
         end
         csb_pkg::KIND_ATTACH_BACK: begin
            if (full) plan.status = csb_pkg::STATUS_FULL;
            else begin
               plan.shift = csb_pkg::SHIFT_UP;
               pos_c      = count;
            end
         end
         csb_pkg::KIND_REMOVE: begin
            if (item) plan.shift = csb_pkg::SHIFT_DOWN;
            else plan.status = csb_pkg::STATUS_NO_ITEM;
         end
         csb_pkg::KIND_REMOVE_FRONT: begin
            if (empty) plan.status = csb_pkg::STATUS_EMPTY;
            else begin
               plan.shift  = csb_pkg::SHIFT_DOWN;
               pos_c       = '0;
               next_cursor = '0;
            end
         end
         csb_pkg::KIND_READ: begin
            if (!item) plan.status = csb_pkg::STATUS_NO_ITEM;
         end
         default: begin
         end
      endcase

      // open a gap: move count-1 down to pos one place up
      // close a gap: move pos+1 up to count-1 one place down
      moves   = '0;
      last_rd = count - One;
      unique case (plan.shift)
         csb_pkg::SHIFT_UP: begin
            moves       = count - pos_c;
            next_cursor = pos_c;
            next_count  = count + One;
         end
         csb_pkg::SHIFT_DOWN: begin
            moves      = count - One - pos_c;
            last_rd    = pos_c + One;
            next_count = count - One;
         end
         default: begin
         end
      endcase
   end

   assign pos      = pos_c[IdxW-1:0];
   assign first_rd = last_rd[IdxW-1:0];

endmodule

/* hdl/csb_checker.sv */
module csb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [csb_pkg::KindW-1:0]       req_kind,
   input logic [csb_pkg::ValueW-1:0]      req_entry,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [csb_pkg::ValueW-1:0]      rsp_current_value,
   input logic                            rsp_has_item,
   input logic [csb_pkg::ItemCountW-1:0]  rsp_item_count,
   input logic [1:0]                      rsp_status
);

   // one request in flight: a transfer closes the request side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_no_item_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_item) |-> (rsp_current_value == '0))
      else $error("value reported without a current item");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == csb_pkg::STATUS_EMPTY))
         |-> ((rsp_item_count == '0) && !rsp_has_item))
      else $error("empty status with stored entries");

   a_no_item_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == csb_pkg::STATUS_NO_ITEM)) |-> !rsp_has_item)
      else $error("no-item status with a current item");

endmodule

bind cursor_sequence_buffer csb_checker u_csb_checker (.*);
